/* design/hrd_pkg.sv */
package hrd_pkg;

    // Word and field widths
    localparam int WORD_W        = 32;
    localparam int TIME_MIN_BITS = 16;
    localparam int TIME_MAX_BITS = 19;
    localparam int TIME_CFG_W    = 5;
    localparam int ROLL_BITS     = 16;
    localparam int HIT_TIME_W    = 35;
    localparam int WIRE_W        = 48;
    localparam int CHAN_N        = 96;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    // Special words
    localparam logic [WORD_W-1:0] END_OF_BANK  = 32'hbabedead;
    localparam logic [WORD_W-1:0] EVENT_MARKER = 32'hdeadbab1;
    localparam logic [WORD_W-1:0] END_WORD     = 32'h2aabaaaa;
    localparam logic [WORD_W-1:0] BEGIN_WORD   = 32'h4c4d4c4c;
    localparam logic [WORD_W-1:0] STUCK_MASK   = 32'hfffeffff;

    // Register indexes and reset values
    localparam logic CFG_IDX_TIME_BITS = 1'b0;
    localparam logic CFG_IDX_MASK      = 1'b1;
    localparam logic [TIME_CFG_W-1:0] CFG_TIME_BITS_RST = 5'd16;
    localparam logic CFG_MASK_RST = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_BEGIN = 2'd1,
        KIND_END   = 2'd2,
        KIND_EOB   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              clr;   // bank restarted before this record
        logic              rep;   // begin record while already armed
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
        logic [WORD_W-1:0] w4;
    } t_entry;

    typedef struct packed {
        logic [TIME_CFG_W-1:0] time_bits;
        logic                  mask;
    } t_cfg;

    typedef struct packed {
        t_kind                 kind;
        logic [HIT_TIME_W-1:0] hit_time;
        logic [WIRE_W-1:0]     x_wires;
        logic [WIRE_W-1:0]     y_wires;
        logic [1:0]            kicker_state;
        logic [6:0]            kicker_count;
        logic [7:0]            prescale;
        logic                  fifo_was_full;
        logic                  checksum_good;
        logic                  repeated_begin;
    } t_result;

    // Channel bitmap (bit k = channel k+1) to wires: {y, x}
    function automatic logic [2*WIRE_W-1:0] wire_map(input logic [CHAN_N-1:0] chan);
        logic [WIRE_W-1:0] x;
        logic [WIRE_W-1:0] y;
        x = '0;
        y = '0;
        x[47:32] = chan[15:0];
        for (int k = 16; k < 32; k++) begin
            x[47-k] = chan[k];
        end
        x[15:0]  = chan[47:32];
        y[47:32] = chan[63:48];
        y[31:16] = chan[79:64];
        y[15:0]  = chan[95:80];
        return {y, x};
    endfunction

endpackage

/* design/hrd_front.sv */
module hrd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [31:0]           i_data_word,
    input  logic                  i_bank_start,
    input  logic                  i_q_ready,
    output logic                  o_in_ready,
    output logic                  o_push,
    output hrd_pkg::t_entry       o_entry
);

    logic [1:0]  r_pos, n_pos, s_pos;
    logic        r_after, n_after, s_after;
    logic        r_armed, n_armed, s_armed;
    logic        r_fin, n_fin, s_fin;
    logic        r_clr_pend, n_clr_pend;
    logic [31:0] r_held [0:2];
    logic        held_we;
    logic        accept;
    logic        at_start;
    logic        is_end;
    logic        is_begin;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;

    // bank_start clears per-bank state before the word is handled
    assign s_pos   = i_bank_start ? 2'd0 : r_pos;
    assign s_after = i_bank_start ? 1'b0 : r_after;
    assign s_armed = i_bank_start ? 1'b0 : r_armed;
    assign s_fin   = i_bank_start ? 1'b0 : r_fin;

    assign at_start = (s_pos == 2'd0) && !s_after;
    assign is_end   = (r_held[1] == hrd_pkg::END_WORD) && (r_held[2] == hrd_pkg::END_WORD);
    assign is_begin = (r_held[0] == hrd_pkg::BEGIN_WORD) && (r_held[1] == hrd_pkg::BEGIN_WORD)
                   && (r_held[2] == hrd_pkg::BEGIN_WORD) && (i_data_word == hrd_pkg::BEGIN_WORD);

    always_comb begin
        n_pos         = r_pos;
        n_after       = r_after;
        n_armed       = r_armed;
        n_fin         = r_fin;
        held_we       = 1'b0;
        o_push        = 1'b0;
        o_entry.kind  = hrd_pkg::KIND_DATA;
        o_entry.clr   = i_bank_start || r_clr_pend;
        o_entry.rep   = s_armed;
        o_entry.w1    = r_held[0];
        o_entry.w2    = r_held[1];
        o_entry.w3    = r_held[2];
        o_entry.w4    = i_data_word;
        if (accept) begin
            n_pos   = s_pos;
            n_after = s_after;
            n_armed = s_armed;
            n_fin   = s_fin;
            priority if (s_fin) begin
                // bank over: words ignored until next bank start
            end else if (at_start && i_data_word == hrd_pkg::END_OF_BANK) begin
                o_push       = 1'b1;
                o_entry.kind = hrd_pkg::KIND_EOB;
                n_fin        = 1'b1;
            end else if (at_start && i_data_word == hrd_pkg::EVENT_MARKER) begin
                n_after = 1'b1;
            end else if (s_pos != 2'd3) begin
                n_after = 1'b0;
                held_we = 1'b1;
                n_pos   = s_pos + 2'd1;
            end else begin
                n_after = 1'b0;
                n_pos   = 2'd0;
                priority if (is_begin) begin
                    o_push       = 1'b1;
                    o_entry.kind = hrd_pkg::KIND_BEGIN;
                    n_armed      = 1'b1;
                end else if (!s_armed) begin
                    // unarmed data or end record: dropped
                end else if (is_end) begin
                    o_push       = 1'b1;
                    o_entry.kind = hrd_pkg::KIND_END;
                    n_fin        = 1'b1;
                end else begin
                    o_push       = 1'b1;
                    o_entry.kind = hrd_pkg::KIND_DATA;
                end
            end
        end
    end

    always_comb begin
        n_clr_pend = r_clr_pend;
        if (o_push) begin
            n_clr_pend = 1'b0;
        end else if (accept && i_bank_start) begin
            n_clr_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 2'd0;
            r_after    <= 1'b0;
            r_armed    <= 1'b0;
            r_fin      <= 1'b0;
            r_clr_pend <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_after    <= n_after;
            r_armed    <= n_armed;
            r_fin      <= n_fin;
            r_clr_pend <= n_clr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (held_we) begin
            r_held[s_pos] <= i_data_word;
        end
    end

endmodule

/* design/hrd_queue.sv */
module hrd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  hrd_pkg::t_entry       i_entry,
    output logic                  o_ready,
    input  logic                  i_pop,
    output logic                  o_valid,
    output hrd_pkg::t_entry       o_entry
);

    hrd_pkg::t_entry                   r_mem [0:hrd_pkg::QUEUE_DEPTH-1];
    logic [hrd_pkg::QUEUE_PTR_W-1:0]   r_wr, r_rd;
    logic [hrd_pkg::QUEUE_CNT_W-1:0]   r_cnt, n_cnt;
    logic                              do_push, do_pop;

    assign o_ready = (r_cnt != hrd_pkg::QUEUE_CNT_W'(hrd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + hrd_pkg::QUEUE_CNT_W'(1);
            2'b01:   n_cnt = r_cnt - hrd_pkg::QUEUE_CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= r_wr + hrd_pkg::QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + hrd_pkg::QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* design/hrd_back.sv */
module hrd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hrd_pkg::t_cfg         i_cfg,
    input  logic                  i_q_valid,
    input  hrd_pkg::t_entry       i_entry,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output hrd_pkg::t_result      o_result
);

    logic [31:0]                       r_cks, n_cks, s_cks;
    logic [hrd_pkg::ROLL_BITS-1:0]     r_rc, n_rc, s_rc;
    logic [hrd_pkg::TIME_MAX_BITS-1:0] r_prev, n_prev, s_prev;
    logic                              r_valid;
    hrd_pkg::t_result                  r_res, n_res;

    logic [hrd_pkg::TIME_CFG_W-1:0]    tb;
    logic [hrd_pkg::TIME_MAX_BITS-1:0] tmask, t;
    logic [hrd_pkg::ROLL_BITS-1:0]     rc_inc;
    logic [hrd_pkg::HIT_TIME_W-1:0]    total;
    logic [31:0]                       m2, m3, m4, xor4, cks_end;
    logic [hrd_pkg::CHAN_N-1:0]        chan;
    logic [2*hrd_pkg::WIRE_W-1:0]      wires;

    assign o_pop       = i_q_valid && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_result    = r_res;

    // per-bank state as seen by this record
    assign s_cks  = i_entry.clr ? '0 : r_cks;
    assign s_rc   = i_entry.clr ? '0 : r_rc;
    assign s_prev = i_entry.clr ? '0 : r_prev;

    always_comb begin
        if (i_cfg.time_bits < hrd_pkg::TIME_CFG_W'(hrd_pkg::TIME_MIN_BITS)) begin
            tb = hrd_pkg::TIME_CFG_W'(hrd_pkg::TIME_MIN_BITS);
        end else if (i_cfg.time_bits > hrd_pkg::TIME_CFG_W'(hrd_pkg::TIME_MAX_BITS)) begin
            tb = hrd_pkg::TIME_CFG_W'(hrd_pkg::TIME_MAX_BITS);
        end else begin
            tb = i_cfg.time_bits;
        end
    end

    // time stamp and rollover extension; t fits below 2^tb so OR replaces add
    assign tmask  = ~({hrd_pkg::TIME_MAX_BITS{1'b1}} << tb);
    assign t      = i_entry.w1[hrd_pkg::TIME_MAX_BITS-1:0] & tmask;
    assign rc_inc = (t < s_prev) ? s_rc + hrd_pkg::ROLL_BITS'(1) : s_rc;
    assign total  = (hrd_pkg::HIT_TIME_W'(rc_inc) << tb) | hrd_pkg::HIT_TIME_W'(t);

    assign xor4    = i_entry.w1 ^ i_entry.w2 ^ i_entry.w3 ^ i_entry.w4;
    assign cks_end = s_cks ^ i_entry.w1 ^ i_entry.w2 ^ i_entry.w3;

    assign m2 = i_cfg.mask ? (i_entry.w2 & hrd_pkg::STUCK_MASK) : i_entry.w2;
    assign m3 = i_cfg.mask ? (i_entry.w3 & hrd_pkg::STUCK_MASK) : i_entry.w3;
    assign m4 = i_cfg.mask ? (i_entry.w4 & hrd_pkg::STUCK_MASK) : i_entry.w4;
    assign chan  = {m4[30:0], m3[30:0], m2[30:0], i_entry.w1[21:19]};
    assign wires = hrd_pkg::wire_map(chan);

    always_comb begin
        n_cks  = s_cks;
        n_rc   = s_rc;
        n_prev = s_prev;
        n_res  = '0;
        n_res.kind = i_entry.kind;
        unique case (i_entry.kind)
            hrd_pkg::KIND_DATA: begin
                n_cks  = s_cks ^ xor4;
                n_rc   = rc_inc;
                n_prev = t;
                n_res.hit_time     = total;
                n_res.x_wires      = wires[hrd_pkg::WIRE_W-1:0];
                n_res.y_wires      = wires[2*hrd_pkg::WIRE_W-1:hrd_pkg::WIRE_W];
                n_res.kicker_state = i_entry.w1[23:22];
                n_res.kicker_count = i_entry.w1[30:24];
            end
            hrd_pkg::KIND_BEGIN: begin
                // a repeated begin is folded in twice and cancels
                n_cks = i_entry.rep ? s_cks : (s_cks ^ xor4);
                n_res.repeated_begin = i_entry.rep;
            end
            hrd_pkg::KIND_END: begin
                n_cks = cks_end;
                n_res.hit_time      = hrd_pkg::HIT_TIME_W'(i_entry.w1[18:0]);
                n_res.prescale      = i_entry.w1[26:19];
                n_res.fifo_was_full = i_entry.w1[30];
                n_res.checksum_good = (i_entry.w4 == cks_end);
            end
            hrd_pkg::KIND_EOB: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cks   <= '0;
            r_rc    <= '0;
            r_prev  <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_cks   <= n_cks;
                r_rc    <= n_rc;
                r_prev  <= n_prev;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

endmodule

/* design/hit_record_decoder.sv */
// Readout-bank word decoder. Takes one 32-bit bank word per request on the
// input channel (raise i_bank_start on the first word of each bank) and
// groups words into four-word records. One result request comes out for each
// begin record, each armed data or end record, and for an end-of-bank word;
// start-of-event markers, the first three words of a record, records seen
// before the begin record and everything after the bank has ended give no
// result. Data results carry the rollover-extended time stamp, kicker fields
// and the x/y wire bitmaps; end results carry prescale, the fifo-full flag
// and the XOR checksum check. Rate: one word per clock while the queue has
// room. A record is queued when the word completing it is accepted and moves
// into the output register, raising o_out_valid, once the output is free.
// The front end classifies words and pushes records into a two-entry queue;
// the back end pops one record a cycle into the output register while that
// register is empty or being read, so the front keeps taking words while a
// result waits, until the queue is full. Configuration writes (index 0: time
// stamp bits, 16..19; index 1: stuck-bit mask) are always accepted and must
// be issued only while the decoder is idle.
module hit_record_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    // word input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic        i_bank_start,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_record_kind,
    output logic [34:0] o_hit_time,
    output logic [47:0] o_x_wires,
    output logic [47:0] o_y_wires,
    output logic [1:0]  o_kicker_state,
    output logic [6:0]  o_kicker_count,
    output logic [7:0]  o_prescale,
    output logic        o_fifo_was_full,
    output logic        o_checksum_good,
    output logic        o_repeated_begin
);

    hrd_pkg::t_cfg    r_cfg;
    hrd_pkg::t_entry  push_entry, q_entry;
    hrd_pkg::t_result result;
    logic             push, q_ready, q_valid, pop;

    assign o_cfg_ready = 1'b1;

    // Config registers: written by index; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_bits <= hrd_pkg::CFG_TIME_BITS_RST;
            r_cfg.mask      <= hrd_pkg::CFG_MASK_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hrd_pkg::CFG_IDX_TIME_BITS: r_cfg.time_bits <= i_cfg_data;
                hrd_pkg::CFG_IDX_MASK:      r_cfg.mask      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front end: record framing, marker skip, arming, end-of-bank
    hrd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_data_word  (i_data_word),
        .i_bank_start (i_bank_start),
        .i_q_ready    (q_ready),
        .o_in_ready   (o_in_ready),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // Record queue decouples framing from decode
    hrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // Back end: checksum, rollover counting, wire mapping, output register
    hrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_entry     (q_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_record_kind    = result.kind;
    assign o_hit_time       = result.hit_time;
    assign o_x_wires        = result.x_wires;
    assign o_y_wires        = result.y_wires;
    assign o_kicker_state   = result.kicker_state;
    assign o_kicker_count   = result.kicker_count;
    assign o_prescale       = result.prescale;
    assign o_fifo_was_full  = result.fifo_was_full;
    assign o_checksum_good  = result.checksum_good;
    assign o_repeated_begin = result.repeated_begin;

endmodule

/* design/hrd_checker.sv */
module hrd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  o_record_kind,
    input  logic [34:0] o_hit_time,
    input  logic [47:0] o_x_wires,
    input  logic [47:0] o_y_wires,
    input  logic [1:0]  o_kicker_state,
    input  logic [6:0]  o_kicker_count,
    input  logic [7:0]  o_prescale,
    input  logic        o_fifo_was_full,
    input  logic        o_checksum_good,
    input  logic        o_repeated_begin
);

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_record_kind)
            && $stable(o_hit_time) && $stable(o_x_wires))
        else $error("result changed while stalled");

    a_eob_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == hrd_pkg::KIND_EOB |->
            o_hit_time == '0 && o_x_wires == '0 && o_y_wires == '0
            && o_prescale == '0 && !o_fifo_was_full && !o_checksum_good
            && !o_repeated_begin)
        else $error("end-of-bank result carries data");

    a_begin_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == hrd_pkg::KIND_BEGIN |->
            o_hit_time == '0 && o_x_wires == '0 && o_y_wires == '0
            && o_kicker_count == '0 && !o_checksum_good)
        else $error("begin result carries data");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == hrd_pkg::KIND_END |->
            o_hit_time[34:19] == '0 && o_x_wires == '0 && o_y_wires == '0
            && o_kicker_state == '0 && !o_repeated_begin)
        else $error("end result fields out of place");

endmodule

bind hit_record_decoder hrd_checker u_hrd_checker (.*);
